### sv/cba_pkg.sv
// ============================================================================
// cba_pkg
// Shared types, codes and helpers of the contiguous block allocator.
// ============================================================================
package cba_pkg;

    localparam int WORD_W  = 32;
    localparam int WORD_SH = 5;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_MARK,
        S_RESP
    } t_state;

    typedef enum logic [0:0] {
        ACT_ALLOC   = 1'b0,
        ACT_RELEASE = 1'b1
    } t_action;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_NO_SPACE = 2'd1,
        STATUS_RANGE    = 2'd2
    } t_status;

    // Result of one map word checked for the end of a fitting free run
    typedef struct packed {
        logic       hit;
        logic [4:0] bit_pos;
    } t_scan_res;

    // Reset image of one map word: reserved blocks and padding past the end are used
    function automatic logic [WORD_W-1:0] init_word(input int unsigned base,
                                                    input int unsigned reserved,
                                                    input int unsigned count);
        logic [WORD_W-1:0] w;
        w = '0;
        for (int b = 0; b < WORD_W; b++) begin
            w[b] = ((base + b) < reserved) || ((base + b) >= count);
        end
        return w;
    endfunction

endpackage

### sv/cba_ram.sv
// ============================================================================
// cba_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ============================================================================
module cba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/cba_word_scan.sv
// ============================================================================
// cba_word_scan
// Finds the first bit of a map word at which the free run reaches the length.
// ============================================================================
module cba_word_scan #(
    parameter int CW = 11
) (
    input  logic [cba_pkg::WORD_W-1:0] i_word,
    input  logic [CW-1:0]              i_run,
    input  logic [CW-1:0]              i_len,
    output cba_pkg::t_scan_res         o_res,
    output logic [CW-1:0]              o_run
);

    localparam int N  = cba_pkg::WORD_W;
    localparam int LV = cba_pkg::WORD_SH;

    logic [N-1:0] any_l [LV+1];
    logic [4:0]   idx_l [LV+1][N];
    logic [CW-1:0] run_j [N];
    logic [N-1:0]  hit;
    logic [N-1:0]  first_hit;
    logic [4:0]    pos;

    // Parallel prefix for the position of the last used bit at or below each bit
    always_comb begin
        for (int j = 0; j < N; j++) begin
            any_l[0][j] = i_word[j];
            idx_l[0][j] = 5'(j);
        end
        for (int l = 0; l < LV; l++) begin
            for (int j = 0; j < N; j++) begin
                if (j >= (1 << l) && !any_l[l][j]) begin
                    any_l[l+1][j] = any_l[l][j - (1 << l)];
                    idx_l[l+1][j] = idx_l[l][j - (1 << l)];
                end else begin
                    any_l[l+1][j] = any_l[l][j];
                    idx_l[l+1][j] = idx_l[l][j];
                end
            end
        end
    end

    always_comb begin
        for (int j = 0; j < N; j++) begin
            if (any_l[LV][j]) begin
                run_j[j] = CW'(5'(j) - idx_l[LV][j]);
            end else begin
                run_j[j] = i_run + CW'(j + 1);
            end
            hit[j] = !i_word[j] && (run_j[j] >= i_len);
        end
        first_hit = hit & (~hit + N'(1));
        pos = '0;
        for (int j = 0; j < N; j++) begin
            if (first_hit[j]) begin
                pos = pos | 5'(j);
            end
        end
    end

    assign o_res.hit     = |hit;
    assign o_res.bit_pos = pos;
    assign o_run         = run_j[N-1];

endmodule

### sv/contiguous_block_allocator_top.sv
// ============================================================================
// contiguous_block_allocator_top
// First-fit contiguous allocator over a used/free map of disk blocks.
// ============================================================================
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+---------------------------------------
//  s_*     | in  | s_tvalid/s_tready  | tuser: action; tdata: length, first
//  m_*     | out | m_tvalid/m_tready  | tdata: status, start block
//
//  An allocate scans the map one 32-block word per cycle through the RAM
//  read port up to the fitting run, then marks the words the run covers,
//  one word read-modify-written per cycle. A release marks the words the
//  range covers free the same way. Rejected requests go straight to the
//  response. After reset a clearing pass writes the reset image, one word
//  per cycle; no item is taken meanwhile.
//  A finished result sits in the output register; the next item is taken
//  while it waits, and only the next result waits for m_tready.
//
module contiguous_block_allocator_top #(
    parameter int BLOCK_COUNT     = 1024,
    parameter int RESERVED_BLOCKS = 1
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [10:0] run_length, [20:11] first_block, [23:21] zero
    input  logic [0:0]  s_tuser,   // [0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [1:0] status, [11:2] start_block, [15:12] zero
);

    localparam int WORDS = (BLOCK_COUNT + cba_pkg::WORD_W - 1) / cba_pkg::WORD_W;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int XW    = AW + cba_pkg::WORD_SH;        // block index incl. padding
    localparam int BW    = $clog2(BLOCK_COUNT + 1);
    localparam int CW    = (BW > 11) ? BW : 11;          // lengths and run counts
    localparam int SW    = (BW > 12) ? BW : 12;          // release range end
    localparam logic [AW-1:0] LAST_W = AW'(WORDS - 1);

    // request fields
    logic                  in_act;
    logic [10:0]           in_len;
    logic [9:0]            in_first;
    logic                  alloc_bad;
    logic [SW-1:0]         rel_sum;
    logic                  rel_bad;
    logic [XW-1:0]         rel_lo;

    // control state
    cba_pkg::t_state       r_state,  n_state;
    logic [AW-1:0]         r_addr,   n_addr;    // clear pointer / next read in mark
    logic [AW-1:0]         r_cur,    n_cur;     // word whose data is on the read port
    logic [AW-1:0]         r_wa,     n_wa;
    logic                  r_issue,  n_issue;
    logic                  r_pend,   n_pend;
    logic                  r_m_valid;

    // payload
    logic [CW-1:0]         r_len,    n_len;
    logic [CW-1:0]         r_run,    n_run;
    logic [XW-1:0]         r_lo,     n_lo;
    logic [XW-1:0]         r_hi,     n_hi;
    logic                  r_set,    n_set;
    cba_pkg::t_status      r_status, n_status;
    logic [9:0]            r_start,  n_start;
    logic [15:0]           r_m_data;

    // RAM port
    logic                  ram_we, ram_re;
    logic [AW-1:0]         ram_waddr, ram_raddr;
    logic [cba_pkg::WORD_W-1:0] ram_wdata, ram_rdata;

    // scan and mark datapath
    cba_pkg::t_scan_res    scan_res;
    logic [CW-1:0]         scan_run;
    logic [XW-1:0]         end_blk;
    logic [XW-1:0]         head_blk;
    logic [4:0]            wa_lo, wa_hi;
    logic [cba_pkg::WORD_W-1:0] mark_mask;
    logic                  out_load;

    assign in_act    = s_tuser[0];
    assign in_len    = s_tdata[10:0];
    assign in_first  = s_tdata[20:11];
    assign alloc_bad = (in_len == '0) || (CW'(in_len) > CW'(BLOCK_COUNT));
    assign rel_sum   = SW'(in_first) + SW'(in_len);
    assign rel_bad   = rel_sum > SW'(BLOCK_COUNT);
    assign rel_lo    = XW'(in_first);

    cba_ram #(
        .WIDTH (cba_pkg::WORD_W),
        .DEPTH (WORDS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    cba_word_scan #(
        .CW (CW)
    ) u_scan (
        .i_word (ram_rdata),
        .i_run  (r_run),
        .i_len  (r_len),
        .o_res  (scan_res),
        .o_run  (scan_run)
    );

    // run ends at the hit bit; head is length-1 blocks below it
    assign end_blk  = {r_cur, scan_res.bit_pos};
    assign head_blk = end_blk - XW'(r_len) + XW'(1);

    // bits of the word being written back that fall inside [r_lo, r_hi]
    assign wa_lo     = (r_wa == r_lo[XW-1:cba_pkg::WORD_SH]) ? r_lo[4:0] : 5'd0;
    assign wa_hi     = (r_wa == r_hi[XW-1:cba_pkg::WORD_SH]) ? r_hi[4:0] : 5'd31;
    assign mark_mask = ({cba_pkg::WORD_W{1'b1}} << wa_lo)
                     & ({cba_pkg::WORD_W{1'b1}} >> (5'd31 - wa_hi));

    assign out_load = (r_state == cba_pkg::S_RESP) && (!r_m_valid || m_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cba_pkg::S_CLEAR;
            r_addr  <= '0;
            r_cur   <= '0;
            r_wa    <= '0;
            r_issue <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_cur   <= n_cur;
            r_wa    <= n_wa;
            r_issue <= n_issue;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len    <= n_len;
        r_run    <= n_run;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_set    <= n_set;
        r_status <= n_status;
        r_start  <= n_start;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (out_load) begin
            r_m_valid <= 1'b1;
        end else if (m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_m_data <= {4'b0000, r_start, r_status};
        end
    end

    assign m_tvalid = r_m_valid;
    assign m_tdata  = r_m_data;
    assign s_tready = (r_state == cba_pkg::S_IDLE);

    // sequencer: clearing pass, first-fit scan, read-modify-write sweep
    always_comb begin
        n_state   = r_state;
        n_addr    = r_addr;
        n_cur     = r_cur;
        n_wa      = r_wa;
        n_issue   = r_issue;
        n_pend    = r_pend;
        n_len     = r_len;
        n_run     = r_run;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_set     = r_set;
        n_status  = r_status;
        n_start   = r_start;
        ram_we    = 1'b0;
        ram_waddr = r_wa;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = r_addr;

        unique case (r_state)
            cba_pkg::S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_addr;
                ram_wdata = cba_pkg::init_word(
                    int'({r_addr, {cba_pkg::WORD_SH{1'b0}}}),
                    RESERVED_BLOCKS, BLOCK_COUNT);
                n_addr    = r_addr + AW'(1);
                if (r_addr == LAST_W) begin
                    n_state = cba_pkg::S_IDLE;
                end
            end

            cba_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    n_start  = '0;
                    n_status = cba_pkg::STATUS_OK;
                    if (in_act == cba_pkg::ACT_ALLOC) begin
                        if (alloc_bad) begin
                            n_status = cba_pkg::STATUS_NO_SPACE;
                            n_state  = cba_pkg::S_RESP;
                        end else begin
                            ram_re    = 1'b1;
                            ram_raddr = '0;
                            n_cur     = '0;
                            n_run     = '0;
                            n_len     = CW'(in_len);
                            n_state   = cba_pkg::S_SCAN;
                        end
                    end else begin
                        if (rel_bad) begin
                            n_status = cba_pkg::STATUS_RANGE;
                            n_state  = cba_pkg::S_RESP;
                        end else if (in_len == '0) begin
                            n_state  = cba_pkg::S_RESP;
                        end else begin
                            n_lo    = rel_lo;
                            n_hi    = XW'(rel_sum - SW'(1));
                            n_set   = 1'b0;
                            n_addr  = rel_lo[XW-1:cba_pkg::WORD_SH];
                            n_issue = 1'b1;
                            n_pend  = 1'b0;
                            n_state = cba_pkg::S_MARK;
                        end
                    end
                end
            end

            cba_pkg::S_SCAN: begin
                // prefetch the next word while this one is checked
                ram_re    = (r_cur != LAST_W);
                ram_raddr = r_cur + AW'(1);
                if (scan_res.hit) begin
                    n_lo     = head_blk;
                    n_hi     = end_blk;
                    n_set    = 1'b1;
                    n_start  = 10'(head_blk);
                    n_addr   = head_blk[XW-1:cba_pkg::WORD_SH];
                    n_issue  = 1'b1;
                    n_pend   = 1'b0;
                    n_state  = cba_pkg::S_MARK;
                end else if (r_cur == LAST_W) begin
                    n_status = cba_pkg::STATUS_NO_SPACE;
                    n_state  = cba_pkg::S_RESP;
                end else begin
                    n_cur = r_cur + AW'(1);
                    n_run = scan_run;
                end
            end

            cba_pkg::S_MARK: begin
                // write back word r_wa while reading word r_addr
                ram_we    = r_pend;
                ram_waddr = r_wa;
                ram_wdata = r_set ? (ram_rdata | mark_mask) : (ram_rdata & ~mark_mask);
                ram_re    = r_issue;
                ram_raddr = r_addr;
                n_pend    = r_issue;
                n_wa      = r_addr;
                if (r_issue) begin
                    if (r_addr == r_hi[XW-1:cba_pkg::WORD_SH]) begin
                        n_issue = 1'b0;
                    end else begin
                        n_addr = r_addr + AW'(1);
                    end
                end else begin
                    n_pend  = 1'b0;
                    n_state = cba_pkg::S_RESP;
                end
            end

            cba_pkg::S_RESP: begin
                if (out_load) begin
                    n_state = cba_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = cba_pkg::S_CLEAR;
                n_addr  = '0;
            end
        endcase
    end

`ifndef SYNTH
    // the map is only written by the clearing pass and the mark sweep
    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cba_pkg::S_IDLE || r_state == cba_pkg::S_RESP) |-> !ram_we)
        else $error("map written outside clear or mark");

    // write-back never strays outside the words of the run being marked
    a_mark_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cba_pkg::S_MARK && ram_we) |->
        (r_wa >= r_lo[XW-1:cba_pkg::WORD_SH] && r_wa <= r_hi[XW-1:cba_pkg::WORD_SH]))
        else $error("mark write outside range");

    // a result only appears after the response state
    a_result_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_tvalid) |-> $past(r_state) == cba_pkg::S_RESP)
        else $error("result without response state");
`endif

endmodule
